// ===== src/rbst_pkg.sv =====
// Shared constants and types for the ray/box slab test pipeline.
package rbst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int NUM_W     = W + 1 + FRAC_BITS;
    localparam int HI_W      = NUM_W - W;
    localparam int LANES     = 6;
    localparam int AXES      = 3;
    localparam int IN_W      = 12 * W;
    localparam int OUT_W     = ((1 + 2 * W + 7) / 8) * 8;

    localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};

    // One divider lane: partial remainder, dividend bits shifting out while
    // quotient bits shift in, divisor magnitude, result sign, overflow flag.
    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] work;
        logic [W-1:0] dmag;
        logic         neg;
        logic         ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [AXES-1:0]       zero;
        logic [AXES-1:0]       in_slab;
    } div_stage_t;

    typedef struct packed {
        logic signed [LANES-1:0][W-1:0] t;
        logic [AXES-1:0]                zero;
        logic [AXES-1:0]                in_slab;
    } sat_stage_t;

    typedef struct packed {
        logic            ok;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
    } ivl_t;

endpackage

// ===== src/ray_box_slab_test.sv =====
// Ray versus axis-aligned box slab test, fully pipelined, one item per cycle while m_axis is not stalled.
// An accepted item passes div_reg[0], the divider stages, sat_reg, ivl_reg and out_reg before it shows on m_axis.
// Throughput: one item per cycle when m_axis does not stall; the 32-stage restoring divider (six lanes,
// one quotient bit per stage) sets the depth.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
// A stall on m_axis freezes the whole pipeline, so nothing is lost or repeated.
module ray_box_slab_test
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
    input  logic [rbst_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // hit, t_enter, t_exit, zero padding
    output logic [rbst_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int W     = rbst_pkg::W;
    localparam int DEPTH = rbst_pkg::W;

    // One restoring-division step: bring down one dividend bit, try subtract.
    function automatic rbst_pkg::div_lane_t div_step(rbst_pkg::div_lane_t l);
        rbst_pkg::div_lane_t r;
        logic [W:0]          trial;
        logic [W:0]          diff;
        r     = l;
        trial = {l.rem, l.work[W-1]};
        diff  = trial - {1'b0, l.dmag};
        if (!diff[W])
        begin
            r.rem  = diff[W-1:0];
            r.work = {l.work[W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = trial[W-1:0];
            r.work = {l.work[W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Narrow the running interval by one slab; miss when disjoint, or when dir is zero and origin is outside.
    function automatic rbst_pkg::ivl_t slab_merge(rbst_pkg::ivl_t cur, logic zero,
                                                  logic in_slab,
                                                  logic signed [W-1:0] t1,
                                                  logic signed [W-1:0] t2);
        rbst_pkg::ivl_t      r;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        r = cur;
        a = (t1 > t2) ? t2 : t1;
        b = (t1 > t2) ? t1 : t2;
        if (cur.ok)
        begin
            if (zero)
            begin
                if (!in_slab)
                    r.ok = 1'b0;
            end
            else if (cur.lo > b || a > cur.hi)
            begin
                r.ok = 1'b0;
            end
            else
            begin
                if (a > cur.lo)
                    r.lo = a;
                if (b < cur.hi)
                    r.hi = b;
            end
        end
        return r;
    endfunction

    logic ce;

    rbst_pkg::div_stage_t prep_next;
    rbst_pkg::div_stage_t div_reg   [0:DEPTH];
    logic                 div_v_reg [0:DEPTH];
    rbst_pkg::sat_stage_t sat_next;
    rbst_pkg::sat_stage_t sat_reg;
    logic                 sat_v_reg;
    rbst_pkg::ivl_t       ivl_next;
    rbst_pkg::ivl_t       ivl_reg;
    logic [rbst_pkg::AXES-1:0] zero_reg;
    logic [rbst_pkg::AXES-1:0] in_slab_reg;
    logic signed [W-1:0]  tz0_reg;
    logic signed [W-1:0]  tz1_reg;
    logic                 ivl_v_reg;
    rbst_pkg::ivl_t       fin_next;
    logic                 out_v_reg;
    logic [rbst_pkg::OUT_W-1:0] out_reg;
    logic [rbst_pkg::OUT_W-1:0] out_next;

    // Advance everything whenever the output slot is free or being taken.
    assign ce            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    // Front end: plane offsets, magnitudes, signs, overflow precheck.
    for (genvar l = 0; l < rbst_pkg::LANES; l++)
    begin : g_prep
        localparam int AX = l % rbst_pkg::AXES;
        logic signed [W-1:0]   bound;
        logic signed [W-1:0]   org;
        logic signed [W-1:0]   dir;
        logic signed [W:0]     diff;
        logic [W:0]            dmag33;
        logic [rbst_pkg::NUM_W-1:0] num;
        logic [W-1:0]          dirmag;
        logic [W-1:0]          num_hi;
        logic                  ovf;

        assign bound  = s_axis_tdata[l*W +: W];
        assign org    = s_axis_tdata[(6+AX)*W +: W];
        assign dir    = s_axis_tdata[(9+AX)*W +: W];
        assign diff   = {bound[W-1], bound} - {org[W-1], org};
        assign dmag33 = diff[W] ? (~diff + 1'b1) : diff;
        assign num    = {dmag33, {rbst_pkg::FRAC_BITS{1'b0}}};
        assign dirmag = dir[W-1] ? (~dir + 1'b1) : dir;
        assign num_hi = W'(num[rbst_pkg::NUM_W-1:W]);
        assign ovf    = num_hi >= dirmag;

        assign prep_next.lane[l].rem  = ovf ? '0 : num_hi;
        assign prep_next.lane[l].work = num[W-1:0];
        assign prep_next.lane[l].dmag = dirmag;
        assign prep_next.lane[l].neg  = diff[W] ^ dir[W-1];
        assign prep_next.lane[l].ovf  = ovf;
    end

    for (genvar a = 0; a < rbst_pkg::AXES; a++)
    begin : g_axis
        logic signed [W-1:0] bmin;
        logic signed [W-1:0] bmax;
        logic signed [W-1:0] org;
        logic signed [W-1:0] dir;
        assign bmin = s_axis_tdata[a*W +: W];
        assign bmax = s_axis_tdata[(3+a)*W +: W];
        assign org  = s_axis_tdata[(6+a)*W +: W];
        assign dir  = s_axis_tdata[(9+a)*W +: W];
        assign prep_next.zero[a]    = (dir == '0);
        assign prep_next.in_slab[a] = (org >= bmin) && (org <= bmax);
    end

    // Divider stages: stage k+1 holds the result of k+1 quotient bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DEPTH; k++)
                div_v_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            div_v_reg[0] <= s_axis_tvalid;
            for (int k = 0; k < DEPTH; k++)
                div_v_reg[k+1] <= div_v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            div_reg[0] <= prep_next;
            for (int k = 0; k < DEPTH; k++)
            begin
                div_reg[k+1].zero    <= div_reg[k].zero;
                div_reg[k+1].in_slab <= div_reg[k].in_slab;
                for (int l = 0; l < rbst_pkg::LANES; l++)
                    div_reg[k+1].lane[l] <= div_step(div_reg[k].lane[l]);
            end
        end
    end

    // Sign and saturate the quotients.
    always_comb
    begin
        sat_next.zero    = div_reg[DEPTH].zero;
        sat_next.in_slab = div_reg[DEPTH].in_slab;
        for (int l = 0; l < rbst_pkg::LANES; l++)
        begin
            if (div_reg[DEPTH].lane[l].neg)
            begin
                if (div_reg[DEPTH].lane[l].ovf ||
                    div_reg[DEPTH].lane[l].work > W'(rbst_pkg::T_MIN))
                    sat_next.t[l] = rbst_pkg::T_MIN;
                else
                    sat_next.t[l] = ~div_reg[DEPTH].lane[l].work + 1'b1;
            end
            else
            begin
                if (div_reg[DEPTH].lane[l].ovf ||
                    div_reg[DEPTH].lane[l].work > W'(rbst_pkg::T_MAX))
                    sat_next.t[l] = rbst_pkg::T_MAX;
                else
                    sat_next.t[l] = div_reg[DEPTH].lane[l].work;
            end
        end
    end

    // Merge x and y slabs into the running interval.
    always_comb
    begin
        rbst_pkg::ivl_t init;
        rbst_pkg::ivl_t after_x;
        init.ok  = 1'b1;
        init.lo  = rbst_pkg::T_MIN;
        init.hi  = rbst_pkg::T_MAX;
        after_x  = slab_merge(init, sat_reg.zero[0], sat_reg.in_slab[0],
                              sat_reg.t[0], sat_reg.t[3]);
        ivl_next = slab_merge(after_x, sat_reg.zero[1], sat_reg.in_slab[1],
                              sat_reg.t[1], sat_reg.t[4]);
    end

    // Merge z and format the result; zero the t fields on a miss.
    always_comb
    begin
        fin_next = slab_merge(ivl_reg, zero_reg[2], in_slab_reg[2], tz0_reg, tz1_reg);
        out_next = '0;
        if (fin_next.ok)
        begin
            out_next[0]         = 1'b1;
            out_next[1 +: W]    = fin_next.lo;
            out_next[1+W +: W]  = fin_next.hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_v_reg <= 1'b0;
            ivl_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            sat_v_reg <= div_v_reg[DEPTH];
            ivl_v_reg <= sat_v_reg;
            out_v_reg <= ivl_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sat_reg     <= sat_next;
            ivl_reg     <= ivl_next;
            zero_reg    <= sat_reg.zero;
            in_slab_reg <= sat_reg.in_slab;
            tz0_reg     <= sat_reg.t[2];
            tz1_reg     <= sat_reg.t[5];
            out_reg     <= out_next;
        end
    end

endmodule

// ===== src/rbst_checker.sv =====
// Port-level checks for the slab test block, bound to the top level.
module rbst_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [rbst_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int W = rbst_pkg::W;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // A miss carries zero t fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2*W:1] == '0)
        else $error("miss with nonzero t fields");

    // A hit has entry not after exit.
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            $signed(m_axis_tdata[W:1]) <= $signed(m_axis_tdata[2*W:W+1]))
        else $error("hit with t_enter after t_exit");

    // Input ready follows the output slot: free slot means ready.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);
